[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hash table RTL. Defining
// ASSERT_OFF turns every use into an empty statement.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Constants, codes and interface types shared by the hash table modules.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // Table geometry and field widths. SLOTS must be a power of two.
    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int HASH_BITS  = 32;
    localparam int LIMIT_W    = 10;
    localparam int COUNT_W    = 11;

    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 10'd768;

    // Configuration register indexes.
    localparam logic REG_LOAD_LIMIT = 1'b0;

    // Command codes.
    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    // Slot status codes.
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_TOMB  = 2'd1;
    localparam logic [1:0] ST_LIVE  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;   // write one status entry empty and advance
        logic load;  // capture a new transaction and start the probe
        logic rd;    // read the slot at the probe index
        logic ev;    // evaluate the slot just read
    } lpht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;  // clearing pass is at the last entry
        logic quick;     // transaction resolves without a probe
        logic finish;    // the slot being evaluated ends the probe
    } lpht_stat_t;

endpackage

[sv/lpht_ctrl.sv]
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller state machine: clearing pass after reset, then one probe step
// (read, evaluate) at a time until the datapath reports the probe finished.
// ----------------------------------------------------------------------------
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  lpht_stat_t stat,
    output lpht_cmd_t  cmd,
    output logic       busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.quick ? S_IDLE : S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.ev     = 1'b1;
                state_next = stat.finish ? S_IDLE : S_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset begins the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[sv/lpht_datapath.sv]
// ----------------------------------------------------------------------------
// lpht_datapath
// Slot memories, probe index and tombstone tracking, used count, and the
// result registers. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module lpht_datapath
    import lpht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpht_cmd_t             cmd,
    output lpht_stat_t            stat,
    input  logic [1:0]            command,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [HASH_BITS-1:0]  key_hash,
    input  logic [VALUE_BITS-1:0] value_in,
    input  logic [LIMIT_W-1:0]    load_limit,
    output logic                  done,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] value_out,
    output logic                  full_res
);

    // Slot memories.
    logic [1:0]            status_mem [SLOTS];
    logic [KEY_BITS-1:0]   key_mem    [SLOTS];
    logic [VALUE_BITS-1:0] value_mem  [SLOTS];

    // Registered read data.
    logic [1:0]            rd_status_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_value_reg;

    // Captured transaction.
    logic [1:0]            cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // Probe state.
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [SLOT_W-1:0]     n_reg, n_next;
    logic                  tomb_valid_reg, tomb_valid_next;
    logic [SLOT_W-1:0]     tomb_idx_reg, tomb_idx_next;
    logic [COUNT_W-1:0]    used_count_reg, used_count_next;

    // Result registers.
    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;
    logic [VALUE_BITS-1:0] vout_reg, vout_next;
    logic                  full_reg, full_next;

    // Evaluation of the slot just read.
    logic                  is_empty, is_live, is_tomb, match, last;
    logic                  finish, resolve, tomb_hit, take_tomb;
    logic [SLOT_W-1:0]     take_idx;

    // Memory write controls.
    logic                  st_we, key_we, val_we;
    logic [SLOT_W-1:0]     wr_addr;
    logic [1:0]            st_wdata;
    logic                  used_inc;
    logic                  res_hit, res_full;
    logic [VALUE_BITS-1:0] res_val;

    // Classify the slot and decide whether the probe ends here.
    always_comb
    begin
        is_empty  = (rd_status_reg == ST_EMPTY);
        is_live   = (rd_status_reg == ST_LIVE);
        is_tomb   = (rd_status_reg == ST_TOMB);
        match     = is_live && (rd_key_reg == key_reg);
        last      = &n_reg;
        finish    = is_empty || match || last;
        resolve   = cmd.ev && finish;
        tomb_hit  = is_tomb && !tomb_valid_reg;
        take_tomb = tomb_valid_reg || tomb_hit;
        take_idx  = tomb_valid_reg ? tomb_idx_reg : idx_reg;
    end

    // Outcome of a finished probe.
    always_comb
    begin
        st_we    = 1'b0;
        key_we   = 1'b0;
        val_we   = 1'b0;
        wr_addr  = idx_reg;
        st_wdata = ST_LIVE;
        used_inc = 1'b0;
        res_hit  = 1'b0;
        res_full = 1'b0;
        res_val  = '0;
        case (cmd_reg)
            CMD_SET:
            begin
                if (match)
                begin
                    val_we = 1'b1;
                end
                else if (take_tomb)
                begin
                    wr_addr = take_idx;
                    st_we   = 1'b1;
                    key_we  = 1'b1;
                    val_we  = 1'b1;
                    res_hit = 1'b1;
                end
                else if (is_empty && (used_count_reg < {1'b0, load_limit}))
                begin
                    st_we    = 1'b1;
                    key_we   = 1'b1;
                    val_we   = 1'b1;
                    used_inc = 1'b1;
                    res_hit  = 1'b1;
                end
                else
                begin
                    res_full = 1'b1;
                end
            end
            CMD_GET:
            begin
                if (match)
                begin
                    res_hit = 1'b1;
                    res_val = rd_value_reg;
                end
            end
            CMD_DEL:
            begin
                if (match)
                begin
                    st_we    = 1'b1;
                    st_wdata = ST_TOMB;
                    res_hit  = 1'b1;
                end
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase

        // Nothing is written unless the probe ends this cycle.
        if (!resolve)
        begin
            st_we    = 1'b0;
            key_we   = 1'b0;
            val_we   = 1'b0;
            used_inc = 1'b0;
        end

        // The clearing pass owns the status write port.
        if (cmd.clr)
        begin
            st_we    = 1'b1;
            wr_addr  = idx_reg;
            st_wdata = ST_EMPTY;
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat.clr_last = &idx_reg;
        stat.quick    = (command == CMD_NOP) ||
                        ((command != CMD_SET) && (used_count_reg == '0));
        stat.finish   = finish;
    end

    // Next values of the probe state and the result registers.
    always_comb
    begin
        idx_next        = idx_reg;
        n_next          = n_reg;
        tomb_valid_next = tomb_valid_reg;
        tomb_idx_next   = tomb_idx_reg;
        used_count_next = used_count_reg + COUNT_W'(used_inc);
        done_next       = 1'b0;
        hit_next        = hit_reg;
        vout_next       = vout_reg;
        full_next       = full_reg;

        if (cmd.clr)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.load)
        begin
            idx_next        = key_hash[SLOT_W-1:0];
            n_next          = '0;
            tomb_valid_next = 1'b0;
            if (stat.quick)
            begin
                done_next = 1'b1;
                hit_next  = 1'b0;
                vout_next = '0;
                full_next = 1'b0;
            end
        end

        if (cmd.ev)
        begin
            if (finish)
            begin
                done_next = 1'b1;
                hit_next  = res_hit;
                vout_next = res_val;
                full_next = res_full;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                n_next   = n_reg + 1'b1;
                if (tomb_hit)
                begin
                    tomb_valid_next = 1'b1;
                    tomb_idx_next   = idx_reg;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            n_reg          <= '0;
            tomb_valid_reg <= 1'b0;
            used_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            tomb_valid_reg <= tomb_valid_next;
            used_count_reg <= used_count_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            key_reg <= key;
            val_reg <= value_in;
        end
        tomb_idx_reg <= tomb_idx_next;
        hit_reg      <= hit_next;
        vout_reg     <= vout_next;
        full_reg     <= full_next;
    end

    // Status memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            status_mem[wr_addr] <= st_wdata;
        end
        if (cmd.rd)
        begin
            rd_status_reg <= status_mem[idx_reg];
        end
    end

    // Key memory.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (cmd.rd)
        begin
            rd_key_reg <= key_mem[idx_reg];
        end
    end

    // Value memory.
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[wr_addr] <= val_reg;
        end
        if (cmd.rd)
        begin
            rd_value_reg <= value_mem[idx_reg];
        end
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign value_out = vout_reg;
    assign full_res  = full_reg;

endmodule

[sv/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key-value table with open addressing, linear probing and tombstones.
// Commands are set, get and delete; a load limit register bounds the number
// of used slots.
//
//   Channel   Handshake                     Payload
//   command   start / busy                  command, key, key_hash, value_in
//   result    done (one-cycle strobe)       hit, value_out, full_res
//   config    APB write/read, pready = 1    load_limit at byte address 0
//
// Each probed slot takes a memory read, then an evaluate step, since the
// slot memories have one registered read port. A transaction probes 1 to
// 1024 slots. A get or delete on an empty table, and an unused command,
// answer without a probe. After reset a clearing pass marks every slot
// empty; busy is high meanwhile. The done strobe cannot be stalled; hit,
// value_out and full_res hold until the next result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            command,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [HASH_BITS-1:0]  key_hash,
    input  logic [VALUE_BITS-1:0] value_in,
    // Result channel
    output logic                  done,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] value_out,
    output logic                  full_res,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    lpht_cmd_t          cmd;
    lpht_stat_t         stat;
    logic [LIMIT_W-1:0] load_limit_reg;
    logic               cfg_wr;

    // Configuration register; writes complete in the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LOAD_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg <= LOAD_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            load_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Read back.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_LOAD_LIMIT)
        begin
            prdata = {{(32 - LIMIT_W){1'b0}}, load_limit_reg};
        end
    end

    lpht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    lpht_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .command    (command),
        .key        (key),
        .key_hash   (key_hash),
        .value_in   (value_in),
        .load_limit (load_limit_reg),
        .done       (done),
        .hit        (hit),
        .value_out  (value_out),
        .full_res   (full_res)
    );

    // An accepted transaction either answers at once or keeps the block busy.
    `ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done, "accepted transaction neither answered nor busy")
    // A refused set never reports a new key.
    `ASSERT_IMPLY(a_full_not_hit, clk, rst_n, done && full_res, !hit, "full and hit reported together")
    // Only a hit returns a nonzero value.
    `ASSERT_IMPLY(a_value_needs_hit, clk, rst_n, done && (value_out != '0), hit && !full_res, "value returned without a hit")
    // Clearing and probing never overlap.
    `ASSERT_IMPLY(a_clear_exclusive, clk, rst_n, cmd.clr, !cmd.rd && !cmd.ev && !cmd.load, "clearing pass overlaps a probe")

endmodule

[verif/linear_probe_hash_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking testbench for the open-addressing hash table. A behavioral
// copy of the table predicts hit, value_out and full_res for every accepted
// command. A checker compares each result strobe against the oldest pending
// prediction. Directed tests cover the empty table, the load limit at both
// ends, overwrites, tombstone reuse and probe wrap-around. Random phases
// then run clustered key pools under several load limits, with random
// sender gaps and pauses that wait for the table to drain.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
    import lpht_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          TAIL_CYCLES    = 100;
    localparam int          POOL_SIZE      = 32;
    localparam int          PHASE_ITEMS    = 166;
    localparam int unsigned NO_SLOT        = 32'hFFFF_FFFF;
    localparam logic [2:0]  LOAD_LIMIT_ADDR = 3'(4 * REG_LOAD_LIMIT);

    // Expected reply of one table operation.
    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value_out;
        logic                  full_res;
    } table_reply_t;

    // DUT connections, all inputs known from time zero.
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic                  busy;
    logic [1:0]            command  = CMD_NOP;
    logic [KEY_BITS-1:0]   key      = '0;
    logic [HASH_BITS-1:0]  key_hash = '0;
    logic [VALUE_BITS-1:0] value_in = '0;
    logic                  done;
    logic                  hit;
    logic [VALUE_BITS-1:0] value_out;
    logic                  full_res;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [2:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Shadow copy of the table contents and the load limit register.
    logic [1:0]            shadow_status [SLOTS];
    logic [KEY_BITS-1:0]   shadow_key    [SLOTS];
    logic [VALUE_BITS-1:0] shadow_value  [SLOTS];
    logic [COUNT_W-1:0]    shadow_used;
    logic [LIMIT_W-1:0]    shadow_limit;

    table_reply_t pending_replies[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           sender_gaps = 1'b1;
    int           set_count   = 0;
    int           get_count   = 0;
    int           del_count   = 0;
    int           nop_count   = 0;
    int           hit_count   = 0;
    int           full_count  = 0;

    logic [KEY_BITS-1:0]  pool_key  [POOL_SIZE];
    logic [HASH_BITS-1:0] pool_hash [POOL_SIZE];

    linear_probe_hash_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .key       (key),
        .key_hash  (key_hash),
        .value_in  (value_in),
        .done      (done),
        .hit       (hit),
        .value_out (value_out),
        .full_res  (full_res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one operation to the shadow table and return its reply.
    function automatic table_reply_t apply_table_op(input logic [1:0] op,
                                                    input logic [KEY_BITS-1:0] k,
                                                    input logic [HASH_BITS-1:0] h,
                                                    input logic [VALUE_BITS-1:0] v);
        table_reply_t reply;
        int unsigned  idx;
        int unsigned  tomb;
        int unsigned  take;
        int unsigned  found;
        bit           stopped;
        reply   = '0;
        tomb    = NO_SLOT;
        take    = NO_SLOT;
        found   = NO_SLOT;
        stopped = 1'b0;
        if (op == CMD_SET || ((op == CMD_GET || op == CMD_DEL) && shadow_used != 0))
        begin
            // Linear probe: stop on a matching live slot or on an empty slot.
            idx = h % 32'(SLOTS);
            for (int n = 0; n < SLOTS && !stopped; n++)
            begin
                if (shadow_status[idx] == ST_EMPTY)
                begin
                    take    = (tomb != NO_SLOT) ? tomb : idx;
                    stopped = 1'b1;
                end
                else if (shadow_status[idx] == ST_LIVE)
                begin
                    if (shadow_key[idx] == k)
                    begin
                        found   = idx;
                        stopped = 1'b1;
                    end
                end
                else if (tomb == NO_SLOT)
                begin
                    tomb = idx;
                end
                idx = (idx + 1) % SLOTS;
            end
            if (!stopped)
                take = tomb;

            if (op == CMD_SET)
            begin
                if (found != NO_SLOT)
                begin
                    shadow_value[found] = v;
                end
                else if (take == NO_SLOT)
                begin
                    reply.full_res = 1'b1;
                end
                else if (shadow_status[take] == ST_TOMB)
                begin
                    // Reusing a tombstone is never refused.
                    shadow_status[take] = ST_LIVE;
                    shadow_key[take]    = k;
                    shadow_value[take]  = v;
                    reply.hit           = 1'b1;
                end
                else if (shadow_used >= shadow_limit)
                begin
                    reply.full_res = 1'b1;
                end
                else
                begin
                    shadow_status[take] = ST_LIVE;
                    shadow_key[take]    = k;
                    shadow_value[take]  = v;
                    shadow_used         = shadow_used + 1'b1;
                    reply.hit           = 1'b1;
                end
            end
            else if (found != NO_SLOT)
            begin
                reply.hit = 1'b1;
                if (op == CMD_GET)
                    reply.value_out = shadow_value[found];
                else
                    shadow_status[found] = ST_TOMB;
            end
        end
        return reply;
    endfunction

    // Send one command and record its predicted reply once it is accepted.
    // The caller is at a rising edge; start stays high for a following command.
    task automatic issue_op(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
                            input logic [HASH_BITS-1:0] h,
                            input logic [VALUE_BITS-1:0] v);
        table_reply_t reply;
        if (sender_gaps && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start    <= 1'b1;
        command  <= op;
        key      <= k;
        key_hash <= h;
        value_in <= v;
        do
            @(posedge clk);
        while (busy);
        reply = apply_table_op(op, k, h, v);
        pending_replies.push_back(reply);
        case (op)
            CMD_SET: set_count++;
            CMD_GET: get_count++;
            CMD_DEL: del_count++;
            default: nop_count++;
        endcase
        if (reply.hit)
            hit_count++;
        if (reply.full_res)
            full_count++;
    endtask

    // Stop sending and wait until every predicted reply has been checked.
    task automatic drain_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready. The caller
    // returns the bus to idle after its last transfer.
    task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
    endtask

    // Program the load limit while the table is idle, then read it back.
    task automatic program_load_limit(input logic [LIMIT_W-1:0] limit);
        logic [31:0] rdata;
        drain_replies();
        while (busy)
            @(posedge clk);
        // Upper data bits are random; the register keeps the low bits only.
        apb_transfer(1'b1, LOAD_LIMIT_ADDR, {22'($urandom()), limit}, rdata);
        shadow_limit = limit;
        apb_transfer(1'b0, LOAD_LIMIT_ADDR, '0, rdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (rdata[LIMIT_W-1:0] !== shadow_limit)
        begin
            $error("load_limit readback: expected %0d, actual %0d",
                   shadow_limit, rdata[LIMIT_W-1:0]);
            error_count++;
        end
    endtask

    // Reset value of the register, and gets and deletes on an empty table.
    task automatic test_empty_table();
        logic [31:0] rdata;
        while (busy)
            @(posedge clk);
        apb_transfer(1'b0, LOAD_LIMIT_ADDR, '0, rdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rdata[LIMIT_W-1:0] !== LOAD_LIMIT_RESET)
        begin
            $error("load_limit reset value: expected %0d, actual %0d",
                   LOAD_LIMIT_RESET, rdata[LIMIT_W-1:0]);
            error_count++;
        end
        issue_op(CMD_GET, '0, '0, '1);
        issue_op(CMD_DEL, '1, '1, '0);
        issue_op(CMD_NOP, 64'h0123_4567_89AB_CDEF, 32'h0000_0010, '1);
        drain_replies();
    endtask

    // Load limit of one: refusals, overwrite and tombstone reuse.
    task automatic test_load_limit_one();
        program_load_limit(10'd1);
        issue_op(CMD_SET, 64'h11, 32'd5, 64'hAAAA_0000_0000_0001);
        issue_op(CMD_SET, 64'h22, 32'd9, 64'hBBBB);        // refused: limit reached
        issue_op(CMD_SET, 64'h11, 32'd5, 64'hCCCC);        // overwrite, key not new
        issue_op(CMD_GET, 64'h11, 32'd5, '0);
        issue_op(CMD_DEL, 64'h11, 32'd5, '0);
        issue_op(CMD_GET, 64'h11, 32'd5, '0);              // miss after delete
        issue_op(CMD_SET, 64'h22, 32'd5, 64'hDDDD);        // takes the tombstone
        issue_op(CMD_SET, 64'h33, 32'd5, 64'hEEEE);        // needs an empty slot: refused
        drain_replies();
    endtask

    // Highest load limit, extreme keys and values, probe wrap past the last slot.
    task automatic test_extremes_and_wrap();
        program_load_limit(10'd1023);
        issue_op(CMD_SET, '0, '1, '1);
        issue_op(CMD_SET, '1, '1, 64'h0123_4567_89AB_CDEF);  // wraps to slot 0
        issue_op(CMD_GET, '1, '1, '0);
        issue_op(CMD_GET, '0, '1, '0);
        issue_op(CMD_SET, '0, '1, '0);
        issue_op(CMD_DEL, '0, '1, '0);
        issue_op(CMD_GET, '1, '1, '0);                       // passes a tombstone
        issue_op(CMD_DEL, '0, '1, '0);
        issue_op(CMD_SET, 64'h8000_0000_0000_0001, 32'h8000_03FF, '1);
        issue_op(CMD_GET, '1, 32'h7FFF_FC00, '0);            // starts at slot 0
        issue_op(CMD_GET, 64'h44, 32'd5, '0);
        issue_op(CMD_NOP, '1, '1, '1);
        drain_replies();
    endtask

    // Random commands over clustered key pools under several load limits.
    task automatic test_random_phases();
        logic [LIMIT_W-1:0]    limit;
        logic [1:0]            op;
        logic [KEY_BITS-1:0]   k;
        logic [HASH_BITS-1:0]  h;
        logic [VALUE_BITS-1:0] v;
        int                    base;
        int                    sel;
        int                    roll;
        int                    want;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       limit = LOAD_LIMIT_RESET;
                1:       begin
                             want  = int'(shadow_used) + 24;
                             limit = (want > 1023) ? 10'd1023 : LIMIT_W'(want);
                         end
                2:       limit = 10'd1023;
                3:       limit = (shadow_used > 1023) ? 10'd1023 : LIMIT_W'(shadow_used);
                default: limit = LIMIT_W'($urandom_range(1, 1023));
            endcase
            program_load_limit(limit);

            // Keys of one phase share a small range of start slots.
            case (phase)
                0:       base = 1016;
                1:       base = 0;
                3:       base = 1020;
                default: base = $urandom_range(0, SLOTS - 1);
            endcase
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pool_key[i]  = {$urandom(), $urandom()};
                pool_hash[i] = $urandom();
                pool_hash[i][SLOT_W-1:0] = SLOT_W'((base + $urandom_range(0, 11)) % SLOTS);
            end

            // The middle phase runs back to back with no sender gaps.
            sender_gaps = (phase != 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    op = CMD_SET;
                else if (roll < 75)
                    op = CMD_GET;
                else if (roll < 95)
                    op = CMD_DEL;
                else
                    op = CMD_NOP;
                sel  = $urandom_range(0, POOL_SIZE - 1);
                k    = pool_key[sel];
                h    = pool_hash[sel];
                v    = {$urandom(), $urandom()};
                roll = $urandom_range(0, 99);
                if (roll < 6 || op == CMD_NOP)
                begin
                    // Unknown key from an arbitrary start slot.
                    k = {$urandom(), $urandom()};
                    h = $urandom();
                end
                else if (roll < 10)
                begin
                    // Known key probed from the wrong start slot.
                    h = $urandom();
                end
                issue_op(op, k, h, v);
                if ($urandom_range(0, 99) == 0)
                    drain_replies();
            end
            sender_gaps = 1'b1;
        end
        drain_replies();
    endtask

    // Compare every result strobe with the oldest pending prediction.
    always @(posedge clk)
    begin
        table_reply_t exp_reply;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result with no pending transaction: hit %0b value_out %h full_res %0b",
                       hit, value_out, full_res);
                error_count++;
            end
            else
            begin
                exp_reply = pending_replies.pop_front();
                if (hit !== exp_reply.hit)
                begin
                    $error("hit: expected %0b, actual %0b", exp_reply.hit, hit);
                    error_count++;
                end
                if (value_out !== exp_reply.value_out)
                begin
                    $error("value_out: expected %h, actual %h", exp_reply.value_out, value_out);
                    error_count++;
                end
                if (full_res !== exp_reply.full_res)
                begin
                    $error("full_res: expected %0b, actual %0b", exp_reply.full_res, full_res);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without an accepted command or a result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_status[i] = ST_EMPTY;
            shadow_key[i]    = '0;
            shadow_value[i]  = '0;
        end
        shadow_used  = '0;
        shadow_limit = LOAD_LIMIT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_load_limit_one();
        test_extremes_and_wrap();
        test_random_phases();

        // Allow time for any stray result after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_replies.size());
            error_count++;
        end

        $display("Ran %0d sets, %0d gets, %0d deletes and %0d unused commands",
                 set_count, get_count, del_count, nop_count);
        $display("Hits %0d, refused sets %0d, slots in use at the end %0d",
                 hit_count, full_count, shadow_used);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
